>>> src/mfud_pkg.sv
// ----------------------------------------------------------------------------
// Motor feedback unwrap decoder package
// Shared widths, constants, register indexes, types and the DLC length table.
// ----------------------------------------------------------------------------
package mfud_pkg;

    localparam int ID_W      = 11;
    localparam int DLC_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int HALF_W    = 16;
    localparam int WORD_W    = 32;
    localparam int CFG_W     = 11;
    localparam int TURN_SHIFT = 13;

    localparam logic [ID_W-1:0]  FEEDBACK_ID_RST = 11'd513;
    localparam logic [LEN_W-1:0] MIN_LENGTH_RST  = 7'd8;

    localparam logic signed [HALF_W-1:0] WRAP_LIMIT_POS = 16'sd4000;
    localparam logic signed [HALF_W-1:0] WRAP_LIMIT_NEG = -16'sd4000;

    typedef enum logic [0:0] {
        CFG_FEEDBACK_ID = 1'b0,
        CFG_MIN_LENGTH  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              accepted;
        logic [HALF_W-1:0] angle;
        logic [HALF_W-1:0] speed;
        logic [HALF_W-1:0] current;
        logic [BYTE_W-1:0] temp;
    } t_frame;

    function automatic logic [LEN_W-1:0] dlc_to_len(input logic [DLC_W-1:0] code);
        logic [LEN_W-1:0] len;
        unique case (code)
            4'd9:    len = 7'd12;
            4'd10:   len = 7'd16;
            4'd11:   len = 7'd20;
            4'd12:   len = 7'd24;
            4'd13:   len = 7'd32;
            4'd14:   len = 7'd48;
            4'd15:   len = 7'd64;
            default: len = {3'b000, code};
        endcase
        return len;
    endfunction

endpackage

>>> src/mfud_frame_if.sv
// ----------------------------------------------------------------------------
// Feedback frame channel
// Valid/ready channel carrying one received CAN feedback frame per beat.
// ----------------------------------------------------------------------------
interface mfud_frame_if;

    logic                         valid;
    logic                         ready;
    logic [mfud_pkg::ID_W-1:0]    frame_id;
    logic [mfud_pkg::DLC_W-1:0]   dlc_code;
    logic [mfud_pkg::BYTE_W-1:0]  byte0;
    logic [mfud_pkg::BYTE_W-1:0]  byte1;
    logic [mfud_pkg::BYTE_W-1:0]  byte2;
    logic [mfud_pkg::BYTE_W-1:0]  byte3;
    logic [mfud_pkg::BYTE_W-1:0]  byte4;
    logic [mfud_pkg::BYTE_W-1:0]  byte5;
    logic [mfud_pkg::BYTE_W-1:0]  byte6;

    modport source (
        output valid, frame_id, dlc_code, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
        input  ready
    );

    modport sink (
        input  valid, frame_id, dlc_code, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
        output ready
    );

endinterface

>>> src/mfud_result_if.sv
// ----------------------------------------------------------------------------
// Decoded feedback channel
// Valid/ready channel carrying one decoded and unwrapped result per beat.
// ----------------------------------------------------------------------------
interface mfud_result_if;

    logic                               valid;
    logic                               ready;
    logic                               accepted;
    logic        [mfud_pkg::HALF_W-1:0] raw_angle;
    logic signed [mfud_pkg::HALF_W-1:0] rotor_speed;
    logic signed [mfud_pkg::HALF_W-1:0] phase_current;
    logic        [mfud_pkg::BYTE_W-1:0] temperature;
    logic signed [mfud_pkg::WORD_W-1:0] turn_count;
    logic signed [mfud_pkg::WORD_W-1:0] multi_turn_angle;
    logic signed [mfud_pkg::WORD_W-1:0] position;

    modport source (
        output valid, accepted, raw_angle, rotor_speed, phase_current, temperature,
               turn_count, multi_turn_angle, position,
        input  ready
    );

    modport sink (
        input  valid, accepted, raw_angle, rotor_speed, phase_current, temperature,
               turn_count, multi_turn_angle, position,
        output ready
    );

endinterface

>>> src/mfud_unpack.sv
// ----------------------------------------------------------------------------
// Feedback frame check and unpack
// Checks identifier and decoded length and splits the big-endian fields.
// ----------------------------------------------------------------------------
module mfud_unpack (
    input  logic [mfud_pkg::ID_W-1:0]   i_frame_id,
    input  logic [mfud_pkg::DLC_W-1:0]  i_dlc_code,
    input  logic [mfud_pkg::BYTE_W-1:0] i_byte0,
    input  logic [mfud_pkg::BYTE_W-1:0] i_byte1,
    input  logic [mfud_pkg::BYTE_W-1:0] i_byte2,
    input  logic [mfud_pkg::BYTE_W-1:0] i_byte3,
    input  logic [mfud_pkg::BYTE_W-1:0] i_byte4,
    input  logic [mfud_pkg::BYTE_W-1:0] i_byte5,
    input  logic [mfud_pkg::BYTE_W-1:0] i_byte6,
    input  logic [mfud_pkg::ID_W-1:0]   i_feedback_id,
    input  logic [mfud_pkg::LEN_W-1:0]  i_min_length,
    output mfud_pkg::t_frame            o_frame
);

    logic [mfud_pkg::LEN_W-1:0] len;

    always_comb begin
        len              = mfud_pkg::dlc_to_len(i_dlc_code);
        o_frame.accepted = (i_frame_id == i_feedback_id) && (len >= i_min_length);
        o_frame.angle    = {i_byte0, i_byte1};
        o_frame.speed    = {i_byte2, i_byte3};
        o_frame.current  = {i_byte4, i_byte5};
        o_frame.temp     = i_byte6;
    end

endmodule

>>> src/motor_feedback_unwrap_decoder.sv
// ----------------------------------------------------------------------------
// Motor feedback unwrap decoder
// Decodes CAN motor feedback frames and tracks the multi-turn encoder angle.
// ----------------------------------------------------------------------------
// A taken frame waits in the input register, then moves on to the result register.
// Throughput: one frame per cycle while the result side is ready; the two registers
// separate the two channels, and the turn state updates as a frame moves on.
// Reset (synchronous, active low) restores the configuration defaults,
// clears the turn state and empties both pipeline registers.
module motor_feedback_unwrap_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [mfud_pkg::CFG_W-1:0]    i_cfg_data,
    mfud_frame_if.sink                    i_frame,
    mfud_result_if.source                 o_result
);

    typedef struct packed {
        logic                        accepted;
        logic [mfud_pkg::HALF_W-1:0] angle;
        logic [mfud_pkg::HALF_W-1:0] speed;
        logic [mfud_pkg::HALF_W-1:0] current;
        logic [mfud_pkg::BYTE_W-1:0] temp;
        logic [mfud_pkg::WORD_W-1:0] turns;
        logic [mfud_pkg::WORD_W-1:0] multi;
        logic [mfud_pkg::WORD_W-1:0] position;
    } t_result;

    logic [mfud_pkg::ID_W-1:0]   r_feedback_id;
    logic [mfud_pkg::LEN_W-1:0]  r_min_length;

    logic                        r_in_vld;
    logic [mfud_pkg::ID_W-1:0]   r_frame_id;
    logic [mfud_pkg::DLC_W-1:0]  r_dlc_code;
    logic [mfud_pkg::BYTE_W-1:0] r_byte0;
    logic [mfud_pkg::BYTE_W-1:0] r_byte1;
    logic [mfud_pkg::BYTE_W-1:0] r_byte2;
    logic [mfud_pkg::BYTE_W-1:0] r_byte3;
    logic [mfud_pkg::BYTE_W-1:0] r_byte4;
    logic [mfud_pkg::BYTE_W-1:0] r_byte5;
    logic [mfud_pkg::BYTE_W-1:0] r_byte6;

    logic                        r_seen_first;
    logic [mfud_pkg::HALF_W-1:0] r_prev_angle;
    logic [mfud_pkg::WORD_W-1:0] r_turns;
    logic [mfud_pkg::WORD_W-1:0] r_start_offset;

    logic                        r_out_vld;
    t_result                     r_res;

    logic                        n_seen_first;
    logic [mfud_pkg::HALF_W-1:0] n_prev_angle;
    logic [mfud_pkg::WORD_W-1:0] n_turns;
    logic [mfud_pkg::WORD_W-1:0] n_start_offset;
    t_result                     n_res;

    mfud_pkg::t_frame                   frm;
    logic                               advance;
    logic                               in_take;
    logic signed [mfud_pkg::HALF_W-1:0] diff;
    logic [mfud_pkg::WORD_W-1:0]        multi;
    logic [mfud_pkg::WORD_W-1:0]        angle_ext;

    mfud_unpack u_unpack (
        .i_frame_id    (r_frame_id),
        .i_dlc_code    (r_dlc_code),
        .i_byte0       (r_byte0),
        .i_byte1       (r_byte1),
        .i_byte2       (r_byte2),
        .i_byte3       (r_byte3),
        .i_byte4       (r_byte4),
        .i_byte5       (r_byte5),
        .i_byte6       (r_byte6),
        .i_feedback_id (r_feedback_id),
        .i_min_length  (r_min_length),
        .o_frame       (frm)
    );

    assign advance        = !r_out_vld || o_result.ready;
    assign in_take        = i_frame.valid && i_frame.ready;
    assign i_frame.ready  = !r_in_vld || advance;

    always_comb begin
        angle_ext      = {{(mfud_pkg::WORD_W-mfud_pkg::HALF_W){1'b0}}, frm.angle};
        diff           = signed'(frm.angle - r_prev_angle);
        n_seen_first   = r_seen_first;
        n_prev_angle   = r_prev_angle;
        n_turns        = r_turns;
        n_start_offset = r_start_offset;
        if (frm.accepted) begin
            n_seen_first = 1'b1;
            n_prev_angle = frm.angle;
            if (!r_seen_first) begin
                n_turns        = '0;
                n_start_offset = angle_ext;
            end else if (diff > mfud_pkg::WRAP_LIMIT_POS) begin
                n_turns = r_turns - 32'd1;
            end else if (diff < mfud_pkg::WRAP_LIMIT_NEG) begin
                n_turns = r_turns + 32'd1;
            end
        end
        multi = (n_turns << mfud_pkg::TURN_SHIFT) + angle_ext;

        n_res = '0;
        if (frm.accepted) begin
            n_res.accepted = 1'b1;
            n_res.angle    = frm.angle;
            n_res.speed    = frm.speed;
            n_res.current  = frm.current;
            n_res.temp     = frm.temp;
            n_res.turns    = n_turns;
            n_res.multi    = multi;
            n_res.position = multi - n_start_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feedback_id <= mfud_pkg::FEEDBACK_ID_RST;
            r_min_length  <= mfud_pkg::MIN_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (mfud_pkg::t_cfg_idx'(i_cfg_idx))
                mfud_pkg::CFG_FEEDBACK_ID: r_feedback_id <= i_cfg_data[mfud_pkg::ID_W-1:0];
                mfud_pkg::CFG_MIN_LENGTH:  r_min_length  <= i_cfg_data[mfud_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_vld <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_frame_id <= i_frame.frame_id;
            r_dlc_code <= i_frame.dlc_code;
            r_byte0    <= i_frame.byte0;
            r_byte1    <= i_frame.byte1;
            r_byte2    <= i_frame.byte2;
            r_byte3    <= i_frame.byte3;
            r_byte4    <= i_frame.byte4;
            r_byte5    <= i_frame.byte5;
            r_byte6    <= i_frame.byte6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first   <= 1'b0;
            r_prev_angle   <= '0;
            r_turns        <= '0;
            r_start_offset <= '0;
            r_out_vld      <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_seen_first   <= n_seen_first;
                r_prev_angle   <= n_prev_angle;
                r_turns        <= n_turns;
                r_start_offset <= n_start_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid            = r_out_vld;
    assign o_result.accepted         = r_res.accepted;
    assign o_result.raw_angle        = r_res.angle;
    assign o_result.rotor_speed      = signed'(r_res.speed);
    assign o_result.phase_current    = signed'(r_res.current);
    assign o_result.temperature      = r_res.temp;
    assign o_result.turn_count       = signed'(r_res.turns);
    assign o_result.multi_turn_angle = signed'(r_res.multi);
    assign o_result.position         = signed'(r_res.position);

endmodule

>>> test/motor_feedback_unwrap_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback unwrap decoder testbench
// Sends CAN feedback frames through the frame channel and checks every decoded
// beat against a model of the identifier and length filter and the turn
// counting. Directed frames cover the filter limits, the wrap thresholds and
// the field extremes. Random phases then run several register settings, with
// random gaps on both channels and a long hold-off on the result side.
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_decoder_tb;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 100;

    localparam logic signed [mfud_pkg::HALF_W-1:0] TURN_THRESHOLD  = 16'sd4000;
    localparam logic        [mfud_pkg::WORD_W-1:0] COUNTS_PER_TURN = 32'd8192;

    typedef logic [mfud_pkg::CFG_W-1:0] t_cfg_word;

    typedef struct packed {
        logic [mfud_pkg::ID_W-1:0]             frame_id;
        logic [mfud_pkg::DLC_W-1:0]            dlc_code;
        logic [6:0][mfud_pkg::BYTE_W-1:0]      payload;
    } t_can_frame;

    typedef struct packed {
        logic                               accepted;
        logic        [mfud_pkg::HALF_W-1:0] raw_angle;
        logic signed [mfud_pkg::HALF_W-1:0] rotor_speed;
        logic signed [mfud_pkg::HALF_W-1:0] phase_current;
        logic        [mfud_pkg::BYTE_W-1:0] temperature;
        logic signed [mfud_pkg::WORD_W-1:0] turn_count;
        logic signed [mfud_pkg::WORD_W-1:0] multi_turn_angle;
        logic signed [mfud_pkg::WORD_W-1:0] position;
    } t_decoded;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [0:0]                  i_cfg_idx;
    logic [mfud_pkg::CFG_W-1:0]  i_cfg_data;

    mfud_frame_if  frame_bus ();
    mfud_result_if result_bus ();

    motor_feedback_unwrap_decoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_frame    (frame_bus),
        .o_result   (result_bus)
    );

    t_can_frame frames_to_send[$];
    t_decoded   decodes_due[$];
    t_can_frame frame_on_bus;

    logic [mfud_pkg::ID_W-1:0]   cur_feedback_id;
    logic [mfud_pkg::LEN_W-1:0]  cur_min_length;
    logic                        seen_first;
    logic [mfud_pkg::HALF_W-1:0] prev_angle;
    logic [mfud_pkg::WORD_W-1:0] turns;
    logic [mfud_pkg::WORD_W-1:0] start_offset;
    logic [mfud_pkg::HALF_W-1:0] walk_angle;

    int error_count;
    int result_count;
    int frame_gap;
    int ready_gap;
    int hold_left;
    int idle_cycles;
    bit burst_mode;
    bit hold_request;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [mfud_pkg::LEN_W-1:0] payload_bytes(
            input logic [mfud_pkg::DLC_W-1:0] code);
        logic [mfud_pkg::LEN_W-1:0] n;
        case (code)
            4'd9:    n = 7'd12;
            4'd10:   n = 7'd16;
            4'd11:   n = 7'd20;
            4'd12:   n = 7'd24;
            4'd13:   n = 7'd32;
            4'd14:   n = 7'd48;
            4'd15:   n = 7'd64;
            default: n = 7'(code);
        endcase
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [mfud_pkg::HALF_W-1:0] next_angle();
        int r;
        logic [mfud_pkg::HALF_W-1:0] step;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            step = 16'($urandom_range(0, 3999));
        end else if (r < 70) begin
            step = 16'($urandom_range(4001, 32767));
        end else if (r < 75) begin
            step = 16'd4000;
        end else if (r < 80) begin
            step = 16'd4001;
        end else begin
            walk_angle = 16'($urandom_range(0, 65535));
            return walk_angle;
        end
        if ($urandom_range(0, 1) == 1) begin
            step = -step;
        end
        walk_angle = walk_angle + step;
        return walk_angle;
    endfunction

    function automatic logic [mfud_pkg::DLC_W-1:0] pick_long_dlc(
            input logic [mfud_pkg::LEN_W-1:0] least);
        logic [mfud_pkg::DLC_W-1:0] code;
        code = 4'($urandom_range(0, 15));
        if (least > 7'd64) begin
            return code;
        end
        while (payload_bytes(code) < least) begin
            code = 4'($urandom_range(0, 15));
        end
        return code;
    endfunction

    task automatic push_frame(input logic [mfud_pkg::ID_W-1:0] id,
                              input logic [mfud_pkg::DLC_W-1:0] dlc,
                              input logic [mfud_pkg::HALF_W-1:0] angle,
                              input logic [mfud_pkg::HALF_W-1:0] speed,
                              input logic [mfud_pkg::HALF_W-1:0] current,
                              input logic [mfud_pkg::BYTE_W-1:0] temp);
        t_can_frame f;
        f.frame_id   = id;
        f.dlc_code   = dlc;
        f.payload[0] = angle[15:8];
        f.payload[1] = angle[7:0];
        f.payload[2] = speed[15:8];
        f.payload[3] = speed[7:0];
        f.payload[4] = current[15:8];
        f.payload[5] = current[7:0];
        f.payload[6] = temp;
        frames_to_send.push_back(f);
    endtask

    task automatic queue_random_frames(input int count, input logic [mfud_pkg::ID_W-1:0] id,
                                       input logic [mfud_pkg::LEN_W-1:0] least);
        int r;
        logic [mfud_pkg::ID_W-1:0]   fid;
        logic [mfud_pkg::DLC_W-1:0]  dlc;
        logic [mfud_pkg::HALF_W-1:0] angle;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            fid = id;
            if (r < 10) begin
                fid = id ^ 11'($urandom_range(1, 2047));
                dlc = 4'($urandom_range(0, 15));
                angle = 16'($urandom_range(0, 65535));
            end else if (r < 20) begin
                dlc = 4'($urandom_range(0, 6));
                angle = 16'($urandom_range(0, 65535));
            end else begin
                dlc = pick_long_dlc(least);
                angle = next_angle();
            end
            push_frame(fid, dlc, angle, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic predict_decode(input t_can_frame f);
        t_decoded d;
        logic [mfud_pkg::HALF_W-1:0] angle;
        logic signed [mfud_pkg::HALF_W-1:0] step;
        logic [mfud_pkg::WORD_W-1:0] multi;
        d = '0;
        if (f.frame_id == cur_feedback_id && payload_bytes(f.dlc_code) >= cur_min_length) begin
            angle = {f.payload[0], f.payload[1]};
            if (!seen_first) begin
                seen_first = 1'b1;
                turns = '0;
                start_offset = {16'd0, angle};
            end else begin
                step = angle - prev_angle;
                if (step > TURN_THRESHOLD) begin
                    turns = turns - 1;
                end else if (step < -TURN_THRESHOLD) begin
                    turns = turns + 1;
                end
            end
            prev_angle = angle;
            multi = turns * COUNTS_PER_TURN + {16'd0, angle};
            d.accepted         = 1'b1;
            d.raw_angle        = angle;
            d.rotor_speed      = {f.payload[2], f.payload[3]};
            d.phase_current    = {f.payload[4], f.payload[5]};
            d.temperature      = f.payload[6];
            d.turn_count       = turns;
            d.multi_turn_angle = multi;
            d.position         = multi - start_offset;
        end
        decodes_due.push_back(d);
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_decode();
        t_decoded got;
        t_decoded want;
        got.accepted         = result_bus.accepted;
        got.raw_angle        = result_bus.raw_angle;
        got.rotor_speed      = result_bus.rotor_speed;
        got.phase_current    = result_bus.phase_current;
        got.temperature      = result_bus.temperature;
        got.turn_count       = result_bus.turn_count;
        got.multi_turn_angle = result_bus.multi_turn_angle;
        got.position         = result_bus.position;
        result_count++;
        if (decodes_due.size() == 0) begin
            report_error($sformatf("beat %0d arrived with no frame outstanding", result_count));
            return;
        end
        want = decodes_due.pop_front();
        if (got.accepted !== want.accepted)
            report_error($sformatf("beat %0d accepted: got %0b, want %0b",
                                   result_count, got.accepted, want.accepted));
        if (got.raw_angle !== want.raw_angle)
            report_error($sformatf("beat %0d raw_angle: got %0h, want %0h",
                                   result_count, got.raw_angle, want.raw_angle));
        if (got.rotor_speed !== want.rotor_speed)
            report_error($sformatf("beat %0d rotor_speed: got %0d, want %0d",
                                   result_count, got.rotor_speed, want.rotor_speed));
        if (got.phase_current !== want.phase_current)
            report_error($sformatf("beat %0d phase_current: got %0d, want %0d",
                                   result_count, got.phase_current, want.phase_current));
        if (got.temperature !== want.temperature)
            report_error($sformatf("beat %0d temperature: got %0h, want %0h",
                                   result_count, got.temperature, want.temperature));
        if (got.turn_count !== want.turn_count)
            report_error($sformatf("beat %0d turn_count: got %0d, want %0d",
                                   result_count, got.turn_count, want.turn_count));
        if (got.multi_turn_angle !== want.multi_turn_angle)
            report_error($sformatf("beat %0d multi_turn_angle: got %0d, want %0d",
                                   result_count, got.multi_turn_angle, want.multi_turn_angle));
        if (got.position !== want.position)
            report_error($sformatf("beat %0d position: got %0d, want %0d",
                                   result_count, got.position, want.position));
    endtask

    always @(posedge i_clk) begin : frame_driver
        bit offering;
        if (!i_rst_n) begin
            frame_bus.valid <= 1'b0;
        end else begin
            offering = frame_bus.valid;
            if (frame_bus.valid && frame_bus.ready) begin
                predict_decode(frame_on_bus);
                offering = 1'b0;
                frame_gap = pick_gap();
            end
            if (!offering) begin
                if (frame_gap > 0) begin
                    frame_gap--;
                    frame_bus.valid <= 1'b0;
                end else if (frames_to_send.size() > 0) begin
                    frame_on_bus = frames_to_send.pop_front();
                    frame_bus.frame_id <= frame_on_bus.frame_id;
                    frame_bus.dlc_code <= frame_on_bus.dlc_code;
                    frame_bus.byte0    <= frame_on_bus.payload[0];
                    frame_bus.byte1    <= frame_on_bus.payload[1];
                    frame_bus.byte2    <= frame_on_bus.payload[2];
                    frame_bus.byte3    <= frame_on_bus.payload[3];
                    frame_bus.byte4    <= frame_on_bus.payload[4];
                    frame_bus.byte5    <= frame_on_bus.payload[5];
                    frame_bus.byte6    <= frame_on_bus.payload[6];
                    frame_bus.valid    <= 1'b1;
                end else begin
                    frame_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        bit take;
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                check_decode();
                ready_gap = pick_gap();
            end
            if (hold_request) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                take = 1'b0;
            end else begin
                take = 1'b1;
            end
            result_bus.ready <= take;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (frame_bus.valid && frame_bus.ready) ||
            (result_bus.valid && result_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("motor_feedback_unwrap_decoder_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic write_register(input mfud_pkg::t_cfg_idx idx,
                                  input logic [mfud_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == mfud_pkg::CFG_FEEDBACK_ID) begin
            cur_feedback_id = value[mfud_pkg::ID_W-1:0];
        end else begin
            cur_min_length = value[mfud_pkg::LEN_W-1:0];
        end
    endtask

    task automatic wait_for_idle();
        @(negedge i_clk);
        while (frames_to_send.size() > 0 || frame_bus.valid || decodes_due.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [mfud_pkg::ID_W-1:0] id,
                             input logic [mfud_pkg::LEN_W-1:0] least,
                             input int count, input bit no_gaps, input bit hold_off);
        write_register(mfud_pkg::CFG_FEEDBACK_ID, t_cfg_word'(id));
        write_register(mfud_pkg::CFG_MIN_LENGTH, t_cfg_word'(least));
        @(negedge i_clk);
        burst_mode = no_gaps;
        queue_random_frames(count, id, least);
        if (hold_off) begin
            hold_request = 1'b1;
        end
        wait_for_idle();
    endtask

    initial begin : stimulus
        logic [mfud_pkg::HALF_W-1:0] a;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = mfud_pkg::CFG_FEEDBACK_ID;
        i_cfg_data       = '0;
        frame_bus.valid    = 1'b0;
        frame_bus.frame_id = '0;
        frame_bus.dlc_code = '0;
        frame_bus.byte0    = '0;
        frame_bus.byte1    = '0;
        frame_bus.byte2    = '0;
        frame_bus.byte3    = '0;
        frame_bus.byte4    = '0;
        frame_bus.byte5    = '0;
        frame_bus.byte6    = '0;
        result_bus.ready   = 1'b0;
        error_count      = 0;
        result_count     = 0;
        frame_gap        = 0;
        ready_gap        = 0;
        hold_left        = 0;
        idle_cycles      = 0;
        burst_mode       = 1'b0;
        hold_request     = 1'b0;
        cur_feedback_id  = mfud_pkg::FEEDBACK_ID_RST;
        cur_min_length   = mfud_pkg::MIN_LENGTH_RST;
        seen_first       = 1'b0;
        prev_angle       = '0;
        turns            = '0;
        start_offset     = '0;
        walk_angle       = 16'($urandom_range(0, 65535));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Rejected frames before the first accepted one must leave the state alone.
        push_frame(mfud_pkg::FEEDBACK_ID_RST ^ 11'd1, 4'd8, 16'h1234, 16'h7FFF, 16'h8000,
                   8'hAA);
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd7, 16'h4321, 16'h1111, 16'h2222, 8'h55);
        push_frame(11'd0, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_frame(11'd2047, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        a = 16'h1000;
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd8, a, 16'h7FFF, 16'h8000, 8'h00);
        a = a + 16'd4000;
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd9, a, 16'h8000, 16'h7FFF, 8'hFF);
        a = a + 16'd4001;
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd10, a, 16'h0001, 16'hFFFE, 8'h01);
        a = a - 16'd4000;
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd11, a, 16'hFFFF, 16'h0000, 8'h80);
        a = a - 16'd4001;
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd12, a, 16'h0000, 16'hFFFF, 8'h7F);
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd13, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd14, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd15, 16'h8000, 16'h5A5A, 16'hA5A5, 8'h3C);
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd8, 16'h0000, 16'hA5A5, 16'h5A5A, 8'hC3);
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd8, 16'h7FFF, 16'h0100, 16'h0080, 8'h10);
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd8, 16'h0100, 16'h1234, 16'h4321, 8'h20);
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd8, 16'hF000, 16'h8001, 16'h7FFE, 8'h40);
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd8, 16'h0100, 16'h0002, 16'hFFFD, 8'h08);
        push_frame(mfud_pkg::FEEDBACK_ID_RST, 4'd0, 16'h0200, 16'h0003, 16'h0004, 8'h04);
        wait_for_idle();

        run_phase(11'd0, 7'd7, 250, 1'b0, 1'b0);
        run_phase(11'd2047, 7'd64, 200, 1'b1, 1'b1);
        run_phase(11'($urandom_range(0, 2047)), 7'd12, 300, 1'b0, 1'b0);
        run_phase(11'($urandom_range(0, 2047)), 7'd127, 50, 1'b0, 1'b0);
        run_phase(11'($urandom_range(0, 2047)), 7'd65, 30, 1'b1, 1'b0);
        run_phase(11'h555, 7'($urandom_range(7, 64)), 300, 1'b0, 1'b0);
        run_phase(11'h2AA, 7'd8, 100, 1'b1, 1'b0);

        if (error_count == 0) begin
            $display("motor_feedback_unwrap_decoder_tb: PASS");
        end else begin
            $display("motor_feedback_unwrap_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule
